### sv/wtpc_pkg.sv
`default_nettype none

package wtpc_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int SLOT_W = 7;
   localparam int COST_W = 16;
   localparam int ACTION_W = 2;

   // Reset value of the slots-per-element register.
   localparam logic [SLOT_W-1:0] SLOTS_RESET = 7'd4;

   // Request action codes.
   typedef enum logic [ACTION_W-1:0] {
      ACT_START     = 2'd0,
      ACT_NEIGHBOR  = 2'd1,
      ACT_CANDIDATE = 2'd2,
      ACT_FINISH    = 2'd3
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic nbr_wr;
      logic cap;
      logic rd_en;
      logic acc_en;
      logic decide;
      logic report;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;
      logic nbr_empty;
      logic last_read;
   } status_type;

endpackage

`default_nettype wire

### sv/window_task_placement_cost_unit.sv
// Task placement cost unit for a mesh of processing elements.
// Requests arrive on the req_ valid/ready channel: start clears the search,
// neighbor stores the position of a placed predecessor or successor,
// candidate scores one element, finish reports the selection. A finish
// yields one transfer on the rsp_ valid/ready channel; other actions yield none.
// slots_per_pe is written through csr_wr_en/csr_wr_data; write it only while
// the unit is idle: the block does not enforce this. The response of a finish
// is valid in the next cycle. A candidate that is full, or that arrives after a
// zero score, is skipped. Else it is scored in the sum, tail and decide states
// (decide alone without neighbors): the neighbor list sits in a memory with one
// registered read port, and the hop sum reads one neighbor per cycle. Reset
// clears the search state and sets slots_per_pe to 4. While a response is held
// and rsp_ready is low, req_ready stays low; the response waits in its output
// register until it is taken.
`default_nettype none

module window_task_placement_cost_unit #(
   parameter int MAX_NEIGHBORS = 16,
   parameter int COORD_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [wtpc_pkg::SLOT_W-1:0]       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wtpc_pkg::ACTION_W-1:0]     req_action,
   input  logic [COORD_BITS-1:0]             req_pos_x,
   input  logic [COORD_BITS-1:0]             req_pos_y,
   input  logic [wtpc_pkg::SLOT_W-1:0]       req_free_slots,
   input  logic [wtpc_pkg::SLOT_W-1:0]       req_same_app_count,
   input  logic                              req_is_current_host,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [COORD_BITS-1:0]             rsp_sel_x,
   output logic [COORD_BITS-1:0]             rsp_sel_y,
   output logic [wtpc_pkg::COST_W-1:0]       rsp_sel_cost,
   output logic                              rsp_neighbor_overflow
);

   import wtpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer for the request handshake and the hop sum.
   wtpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_action(req_action),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Neighbor memory, scoring arithmetic and selection registers.
   wtpc_datapath #(
      .MAX_NEIGHBORS(MAX_NEIGHBORS),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_free_slots       (req_free_slots),
      .req_same_app_count   (req_same_app_count),
      .req_is_current_host  (req_is_current_host),
      .cmd                  (cmd),
      .status               (status),
      .rsp_found            (rsp_found),
      .rsp_sel_x            (rsp_sel_x),
      .rsp_sel_y            (rsp_sel_y),
      .rsp_sel_cost         (rsp_sel_cost),
      .rsp_neighbor_overflow(rsp_neighbor_overflow)
   );

endmodule

`default_nettype wire

### sv/wtpc_datapath.sv
`default_nettype none

module wtpc_datapath #(
   parameter int MAX_NEIGHBORS = 16,
   parameter int COORD_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [wtpc_pkg::SLOT_W-1:0]   csr_wr_data,
   input  logic [COORD_BITS-1:0]         req_pos_x,
   input  logic [COORD_BITS-1:0]         req_pos_y,
   input  logic [wtpc_pkg::SLOT_W-1:0]   req_free_slots,
   input  logic [wtpc_pkg::SLOT_W-1:0]   req_same_app_count,
   input  logic                          req_is_current_host,
   input  wtpc_pkg::cmd_type             cmd,
   output wtpc_pkg::status_type          status,
   output logic                          rsp_found,
   output logic [COORD_BITS-1:0]         rsp_sel_x,
   output logic [COORD_BITS-1:0]         rsp_sel_y,
   output logic [wtpc_pkg::COST_W-1:0]   rsp_sel_cost,
   output logic                          rsp_neighbor_overflow
);

   import wtpc_pkg::*;

   localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
   localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int HOP_W = COORD_BITS + 1;
   localparam int BASE_W = SLOT_W + 5;

   logic [SLOT_W-1:0]       slots_ff;
   logic [CNT_W-1:0]        nbr_count_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic [2*COORD_BITS-1:0] nbr_mem [MAX_NEIGHBORS];
   logic [2*COORD_BITS-1:0] rd_data_ff;
   logic [COORD_BITS-1:0]   cand_x_ff;
   logic [COORD_BITS-1:0]   cand_y_ff;
   logic [COST_W-1:0]       acc_ff;
   logic [COST_W-1:0]       acc_in;
   logic [COST_W-1:0]       best_cost_ff;
   logic [COORD_BITS-1:0]   best_x_ff;
   logic [COORD_BITS-1:0]   best_y_ff;
   logic                    have_best_ff;
   logic                    zero_hit_ff;
   logic                    overflowed_ff;

   logic                    nbr_full;
   logic [SLOT_W:0]         eff_free;
   logic [SLOT_W-1:0]       eff_same;
   logic [SLOT_W+1:0]       used;
   logic [SLOT_W+1:0]       spare;
   logic [BASE_W-1:0]       base_cost;
   logic [COORD_BITS-1:0]   nbr_x;
   logic [COORD_BITS-1:0]   nbr_y;
   logic [COORD_BITS-1:0]   dx;
   logic [COORD_BITS-1:0]   dy;
   logic [HOP_W-1:0]        hop;
   logic [COST_W:0]         acc_sum;
   logic                    better;

   // Slot terms of the score, from the request payload and the slots register.
   // The current host returns the slot its task holds.
   always_comb begin
      eff_free = {1'b0, req_free_slots} + (SLOT_W + 1)'(req_is_current_host);
      eff_same = (req_is_current_host && (req_same_app_count != '0)) ?
                 req_same_app_count - SLOT_W'(1) : req_same_app_count;
      used  = {1'b0, eff_free} + {2'b00, eff_same};
      spare = ({2'b00, slots_ff} > used) ? ({2'b00, slots_ff} - used) : '0;
      base_cost = {{(BASE_W - SLOT_W - 4){1'b0}}, spare, 2'b00} +
                  {{(BASE_W - SLOT_W - 1){1'b0}}, eff_same, 1'b0};
   end

   // Hop distance from the candidate to the neighbor just read.
   always_comb begin
      nbr_x = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
      nbr_y = rd_data_ff[COORD_BITS-1:0];
      dx = (cand_x_ff > nbr_x) ? cand_x_ff - nbr_x : nbr_x - cand_x_ff;
      dy = (cand_y_ff > nbr_y) ? cand_y_ff - nbr_y : nbr_y - cand_y_ff;
      hop = {1'b0, dx} + {1'b0, dy};
      acc_sum = {1'b0, acc_ff} + (COST_W + 1)'(hop);
      acc_in = acc_sum[COST_W] ? '1 : acc_sum[COST_W-1:0];
   end

   assign nbr_full = (nbr_count_ff == CNT_W'(MAX_NEIGHBORS));
   assign better = !have_best_ff || (acc_ff < best_cost_ff);

   // Status back to the controller.
   assign status.skip      = zero_hit_ff || (eff_free == '0);
   assign status.nbr_empty = (nbr_count_ff == '0);
   assign status.last_read = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == nbr_count_ff);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else if (csr_wr_en) begin
         slots_ff <= csr_wr_data;
      end
   end

   // Neighbor list storage with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.nbr_wr && !nbr_full) begin
         nbr_mem[nbr_count_ff[IDX_W-1:0]] <= {req_pos_x, req_pos_y};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= nbr_mem[rd_idx_ff];
      end
   end

   // Neighbor fill count and overflow flag.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         nbr_count_ff  <= '0;
         overflowed_ff <= 1'b0;
      end else if (cmd.nbr_wr) begin
         if (nbr_full) begin
            overflowed_ff <= 1'b1;
         end else begin
            nbr_count_ff <= nbr_count_ff + CNT_W'(1);
         end
      end
   end

   // Candidate capture, read index and cost accumulator.
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         cand_x_ff <= req_pos_x;
         cand_y_ff <= req_pos_y;
         acc_ff    <= COST_W'(base_cost);
         rd_idx_ff <= '0;
      end else begin
         if (cmd.acc_en) begin
            acc_ff <= acc_in;
         end
         if (cmd.rd_en) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         end
      end
   end

   // Best candidate so far; the first minimum wins and a zero score freezes it.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         best_cost_ff <= '1;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         have_best_ff <= 1'b0;
         zero_hit_ff  <= 1'b0;
      end else if (cmd.decide) begin
         if (better) begin
            best_cost_ff <= acc_ff;
            best_x_ff    <= cand_x_ff;
            best_y_ff    <= cand_y_ff;
            have_best_ff <= 1'b1;
         end
         if (acc_ff == '0) begin
            zero_hit_ff <= 1'b1;
         end
      end
   end

   // Response payload register, loaded on a finish transfer.
   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_found             <= have_best_ff;
         rsp_sel_x             <= best_x_ff;
         rsp_sel_y             <= best_y_ff;
         rsp_sel_cost          <= best_cost_ff;
         rsp_neighbor_overflow <= overflowed_ff;
      end
   end

endmodule

`default_nettype wire

### sv/wtpc_ctrl.sv
`default_nettype none

module wtpc_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wtpc_pkg::ACTION_W-1:0]     req_action,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  wtpc_pkg::status_type              status,
   output wtpc_pkg::cmd_type                 cmd
);

   import wtpc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SUM    = 4'b0010,
      ST_TAIL   = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic       rd_pend_ff;
   logic       rd_pend_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_xfer;
   action_type action;

   assign action    = action_type'(req_action);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      rd_pend_in = rd_pend_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_pend_in = 1'b0;
            if (req_xfer) begin
               unique case (action)
                  ACT_START:    cmd.clear  = 1'b1;
                  ACT_NEIGHBOR: cmd.nbr_wr = 1'b1;
                  ACT_CANDIDATE: begin
                     cmd.cap = 1'b1;
                     if (!status.skip) begin
                        state_in = status.nbr_empty ? ST_DECIDE : ST_SUM;
                     end
                  end
                  ACT_FINISH:   cmd.report = 1'b1;
               endcase
            end
         end
         ST_SUM: begin
            // One neighbor read per cycle; each add uses the registered data of the read before it.
            cmd.rd_en  = 1'b1;
            cmd.acc_en = rd_pend_ff;
            rd_pend_in = 1'b1;
            if (status.last_read) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            cmd.acc_en = 1'b1;
            rd_pend_in = 1'b0;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set by a finish transfer, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_cand_to_sum: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_action == ACT_CANDIDATE) && !status.skip && !status.nbr_empty)
      |=> (state_ff == ST_SUM))
      else $error("candidate with neighbors did not start the hop sum");

   a_last_to_tail: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SUM) && status.last_read) |=> (state_ff == ST_TAIL))
      else $error("hop sum did not end after the last neighbor");

   a_tail_to_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL) |=> (state_ff == ST_DECIDE && !rd_pend_ff))
      else $error("compare step did not follow the last add");

   a_finish_resp: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_action == ACT_FINISH)) |=> rsp_valid_ff)
      else $error("finish transfer produced no response");
`endif

endmodule

`default_nettype wire

### tb/tb_window_task_placement_cost_unit.sv
`timescale 1ns / 100ps

module tb_window_task_placement_cost_unit;
   import wtpc_pkg::*;

   localparam int NBR_CAPACITY = 16;
   localparam int COST_CEILING = 65535;
   localparam int PHASE_ITEMS = 228;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD_CYCLES = 400;

   // One request item and one response item, at the block's widths.
   typedef struct {
      action_type act;
      logic [3:0] px;
      logic [3:0] py;
      logic [SLOT_W-1:0] free;
      logic [SLOT_W-1:0] same;
      logic host;
   } place_req_type;

   typedef struct {
      logic found;
      logic [3:0] sx;
      logic [3:0] sy;
      logic [COST_W-1:0] cost;
      logic ovf;
   } place_rsp_type;

   // A directed stimulus row: repeated rep times, with an optional typed-in result.
   typedef struct {
      place_req_type req;
      int rep;
      bit typed;
      place_rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [SLOT_W-1:0] csr_wr_data;
   logic req_valid;
   logic req_ready;
   logic [ACTION_W-1:0] req_action;
   logic [3:0] req_pos_x;
   logic [3:0] req_pos_y;
   logic [SLOT_W-1:0] req_free_slots;
   logic [SLOT_W-1:0] req_same_app_count;
   logic req_is_current_host;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_found;
   logic [3:0] rsp_sel_x;
   logic [3:0] rsp_sel_y;
   logic [COST_W-1:0] rsp_sel_cost;
   logic rsp_neighbor_overflow;

   // Shadow of the selection state and the slots register.
   logic [SLOT_W-1:0] slots_cfg;
   logic [3:0] nbr_px [NBR_CAPACITY];
   logic [3:0] nbr_py [NBR_CAPACITY];
   int nbr_count;
   int unsigned best_cost;
   logic [3:0] best_x;
   logic [3:0] best_y;
   bit have_best;
   bit zero_hit;
   bit nbr_overflowed;

   place_rsp_type selection_q[$];
   stim_row_type stim_rows[$];
   place_rsp_type no_rsp;
   int mismatch_count = 0;
   int items_sent = 0;
   bit idle_on = 1'b1;
   bit hold_rsp_request = 1'b0;

   window_task_placement_cost_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .req_free_slots        (req_free_slots),
      .req_same_app_count    (req_same_app_count),
      .req_is_current_host   (req_is_current_host),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_found             (rsp_found),
      .rsp_sel_x             (rsp_sel_x),
      .rsp_sel_y             (rsp_sel_y),
      .rsp_sel_cost          (rsp_sel_cost),
      .rsp_neighbor_overflow (rsp_neighbor_overflow)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the run hangs.
   initial begin
      #8_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Clears the shadow search state, as a start does.
   function automatic void clear_search_state();
      nbr_count = 0;
      best_cost = COST_CEILING;
      best_x = '0;
      best_y = '0;
      have_best = 1'b0;
      zero_hit = 1'b0;
      nbr_overflowed = 1'b0;
   endfunction

   // Applies one request to the shadow state; returns 1 when it yields a response.
   function automatic bit predict_placement(input place_req_type it,
                                            output place_rsp_type r);
      int unsigned eff_free;
      int unsigned eff_same;
      int unsigned used;
      int unsigned cost;
      int i;
      r = '{found: 1'b0, sx: '0, sy: '0, cost: '0, ovf: 1'b0};
      predict_placement = 1'b0;
      case (it.act)
         ACT_START: begin
            clear_search_state();
         end
         ACT_NEIGHBOR: begin
            if (nbr_count < NBR_CAPACITY) begin
               nbr_px[nbr_count] = it.px;
               nbr_py[nbr_count] = it.py;
               nbr_count++;
            end else begin
               nbr_overflowed = 1'b1;
            end
         end
         ACT_CANDIDATE: begin
            eff_free = 32'(it.free) + 32'(it.host);
            if (!zero_hit && eff_free != 0) begin
               eff_same = 32'(it.same);
               // The current host gives back the slot this task holds.
               if (it.host && eff_same > 0) eff_same--;
               used = eff_free + eff_same;
               cost = (32'(slots_cfg) > used) ? (32'(slots_cfg) - used) * 4 : 0;
               cost += eff_same * 2;
               for (i = 0; i < nbr_count; i++) begin
                  cost += (it.px > nbr_px[i]) ? 32'(it.px - nbr_px[i]) :
                                                32'(nbr_px[i] - it.px);
                  cost += (it.py > nbr_py[i]) ? 32'(it.py - nbr_py[i]) :
                                                32'(nbr_py[i] - it.py);
               end
               if (cost > COST_CEILING) cost = COST_CEILING;
               if (!have_best || cost < best_cost) begin
                  best_cost = cost;
                  best_x = it.px;
                  best_y = it.py;
                  have_best = 1'b1;
               end
               if (cost == 0) zero_hit = 1'b1;
            end
         end
         default: begin
            r.found = have_best;
            r.sx = have_best ? best_x : 4'd0;
            r.sy = have_best ? best_y : 4'd0;
            r.cost = have_best ? best_cost[COST_W-1:0] : COST_W'(COST_CEILING);
            r.ovf = nbr_overflowed;
            predict_placement = 1'b1;
         end
      endcase
   endfunction

   function automatic void add_row(input action_type a, input int x, input int y,
                                   input int fs, input int same, input int host,
                                   input int rep, input bit typed, input int f,
                                   input int sx, input int sy, input int cost,
                                   input int ovf);
      stim_row_type row;
      row.req = '{act: a, px: 4'(x), py: 4'(y), free: SLOT_W'(fs),
                  same: SLOT_W'(same), host: 1'(host)};
      row.rep = rep;
      row.typed = typed;
      row.rsp = '{found: 1'(f), sx: 4'(sx), sy: 4'(sy), cost: COST_W'(cost),
                  ovf: 1'(ovf)};
      stim_rows.push_back(row);
   endfunction

   // Offers one request and returns at the edge where it transfers.
   task automatic send_req(input place_req_type it, input bit typed,
                           input place_rsp_type typed_rsp);
      place_rsp_type r;
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (predict_placement(it, r)) selection_q.push_back(typed ? typed_rsp : r);
      req_valid <= 1'b1;
      req_action <= it.act;
      req_pos_x <= it.px;
      req_pos_y <= it.py;
      req_free_slots <= it.free;
      req_same_app_count <= it.same;
      req_is_current_host <= it.host;
      items_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering, waits for every outstanding selection, then lets the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (selection_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_slots(input int value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= SLOT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      slots_cfg = SLOT_W'(value);
   endtask

   // One placement decision: start, neighbors, candidates and finish, sometimes broken.
   task automatic run_sequence();
      int n_nbr;
      int n_cand;
      int mode;
      int k;
      bit cluster;
      bit have_last;
      logic [3:0] cx;
      logic [3:0] cy;
      place_req_type it;
      place_req_type last_cand;
      cluster = ($urandom_range(0, 3) == 0);
      cx = 4'($urandom_range(0, 15));
      cy = 4'($urandom_range(0, 15));
      have_last = 1'b0;
      it = '{act: ACT_START, px: 4'($urandom_range(0, 15)), py: 4'($urandom_range(0, 15)),
             free: SLOT_W'($urandom_range(0, 127)), same: SLOT_W'($urandom_range(0, 127)),
             host: 1'($urandom_range(0, 1))};
      // A missing start lets neighbors pile up from the last decision.
      if ($urandom_range(0, 9) != 0) send_req(it, 1'b0, no_rsp);

      mode = $urandom_range(0, 9);
      if (mode == 0) n_nbr = 0;
      else if (mode == 1) n_nbr = $urandom_range(17, 20);
      else n_nbr = $urandom_range(1, 8);
      for (k = 0; k < n_nbr; k++) begin
         it.act = ACT_NEIGHBOR;
         it.px = cluster ? cx : 4'($urandom_range(0, 15));
         it.py = cluster ? cy : 4'($urandom_range(0, 15));
         it.free = SLOT_W'($urandom_range(0, 127));
         it.same = SLOT_W'($urandom_range(0, 127));
         it.host = 1'($urandom_range(0, 1));
         send_req(it, 1'b0, no_rsp);
      end

      n_cand = $urandom_range(1, 8);
      for (k = 0; k < n_cand; k++) begin
         it.act = ACT_CANDIDATE;
         it.px = 4'($urandom_range(0, 15));
         it.py = 4'($urandom_range(0, 15));
         it.host = 1'($urandom_range(0, 1));
         mode = $urandom_range(0, 9);
         if (mode <= 1) begin
            // Exactly full use of the slots with no same-application tasks.
            if (cluster) begin
               it.px = cx;
               it.py = cy;
            end
            it.same = '0;
            it.free = (slots_cfg > SLOT_W'(it.host)) ? slots_cfg - SLOT_W'(it.host) : '0;
         end else if (mode == 2) begin
            it.free = '0;
            it.host = 1'b0;
            it.same = SLOT_W'($urandom_range(0, 64));
         end else if (mode == 3 && have_last) begin
            it = last_cand;
         end else if (mode == 4) begin
            it.free = SLOT_W'($urandom_range(0, 127));
            it.same = SLOT_W'($urandom_range(0, 127));
         end else begin
            it.free = SLOT_W'($urandom_range(0, slots_cfg));
            it.same = SLOT_W'($urandom_range(0, 8));
         end
         last_cand = it;
         have_last = 1'b1;
         send_req(it, 1'b0, no_rsp);
      end

      // Occasional noise: items of any action with arbitrary fields.
      if ($urandom_range(0, 9) == 0) begin
         for (k = $urandom_range(1, 3); k > 0; k--) begin
            it = '{act: action_type'($urandom_range(0, 3)),
                   px: 4'($urandom_range(0, 15)), py: 4'($urandom_range(0, 15)),
                   free: SLOT_W'($urandom_range(0, 127)),
                   same: SLOT_W'($urandom_range(0, 127)),
                   host: 1'($urandom_range(0, 1))};
            send_req(it, 1'b0, no_rsp);
         end
      end

      it.act = ACT_FINISH;
      if ($urandom_range(0, 11) != 0) send_req(it, 1'b0, no_rsp);
      if ($urandom_range(0, 5) == 0) send_req(it, 1'b0, no_rsp);
   endtask

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [COST_W-1:0] want,
                              input logic [COST_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each response transfer with the oldest predicted selection.
   always @(posedge clock) begin
      place_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (selection_q.size() == 0) begin
            $display({"%0t: response transfer with none expected, expected none, ",
                      "actual found %0d x %0d y %0d cost %0d"},
                     $time, rsp_found, rsp_sel_x, rsp_sel_y, rsp_sel_cost);
            mismatch_count++;
         end else begin
            want = selection_q.pop_front();
            check_field("found", COST_W'(want.found), COST_W'(rsp_found));
            check_field("sel_x", COST_W'(want.sx), COST_W'(rsp_sel_x));
            check_field("sel_y", COST_W'(want.sy), COST_W'(rsp_sel_y));
            check_field("sel_cost", want.cost, rsp_sel_cost);
            check_field("neighbor_overflow", COST_W'(want.ovf),
                        COST_W'(rsp_neighbor_overflow));
         end
      end
   end

   // Main sequence: reset, directed rows, then random phases over several slot settings.
   initial begin : main_seq
      int phase;
      int phase_start;
      int slots_plan [5];
      slots_plan = '{1, 64, 0, 127, 4};
      no_rsp = '{found: 1'b0, sx: '0, sy: '0, cost: '0, ovf: 1'b0};
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_action <= ACT_START;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_free_slots <= '0;
      req_same_app_count <= '0;
      req_is_current_host <= 1'b0;
      slots_cfg = SLOTS_RESET;
      clear_search_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows run with the reset value of four slots per element.
      add_row(ACT_CANDIDATE, 3, 5, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_FINISH, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 65535, 0);
      add_row(ACT_CANDIDATE, 15, 15, 2, 1, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_CANDIDATE, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_FINISH, 0, 0, 0, 0, 0, 1, 1, 1, 15, 15, 6, 0);
      add_row(ACT_START, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_NEIGHBOR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_NEIGHBOR, 15, 15, 127, 127, 1, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_CANDIDATE, 0, 0, 4, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_CANDIDATE, 15, 0, 127, 127, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_FINISH, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_START, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_CANDIDATE, 7, 9, 3, 0, 1, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_CANDIDATE, 1, 1, 4, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_FINISH, 0, 0, 0, 0, 0, 1, 1, 1, 7, 9, 0, 0);
      add_row(ACT_FINISH, 0, 0, 0, 0, 0, 1, 1, 1, 7, 9, 0, 0);
      add_row(ACT_START, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_NEIGHBOR, 15, 0, 0, 0, 0, 17, 0, 0, 0, 0, 0, 0);
      add_row(ACT_CANDIDATE, 0, 15, 64, 64, 1, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_FINISH, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_START, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_FINISH, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 65535, 0);
      foreach (stim_rows[i]) begin
         repeat (stim_rows[i].rep) send_req(stim_rows[i].req, stim_rows[i].typed,
                                            stim_rows[i].rsp);
      end
      drain_results();

      // Random phases; the slots register only changes while the block is idle.
      for (phase = 0; phase < 8; phase++) begin
         write_slots(phase < 5 ? slots_plan[phase] : $urandom_range(1, 64));
         idle_on = (phase != 7);
         // Long receiver hold-off while the sender keeps offering.
         if (phase == 1) hold_rsp_request = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) run_sequence();
         send_req('{act: ACT_FINISH, px: '0, py: '0, free: '0, same: '0, host: 1'b0},
                  1'b0, no_rsp);
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
sv/wtpc_pkg.sv
sv/wtpc_datapath.sv
sv/wtpc_ctrl.sv
sv/window_task_placement_cost_unit.sv
tb/tb_window_task_placement_cost_unit.sv
